### hw/rtl/bin7seg_pkg.sv
`timescale 1ns / 1ps

package bin7seg_pkg;

  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned SEL_W     = 3;
  localparam int unsigned SEG_W     = 8;
  localparam int unsigned NUM_DIG   = 4;
  localparam int unsigned RECIP_W   = 17;
  localparam int unsigned PROD_W    = VALUE_W + RECIP_W;

  // Digit positions on the display
  localparam logic [SEL_W-1:0] SEL_ONES      = 3'd0;
  localparam logic [SEL_W-1:0] SEL_TENS      = 3'd1;
  localparam logic [SEL_W-1:0] SEL_HUNDREDS  = 3'd3;
  localparam logic [SEL_W-1:0] SEL_THOUSANDS = 3'd4;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

  // floor(x / d) == (x * m) >> k, exact for every 16-bit x
  localparam logic [RECIP_W-1:0] RECIP_10    = 17'd52429;
  localparam logic [RECIP_W-1:0] RECIP_100   = 17'd83887;
  localparam logic [RECIP_W-1:0] RECIP_1000  = 17'd67109;
  localparam logic [RECIP_W-1:0] RECIP_10000 = 17'd107375;
  localparam int unsigned SHIFT_10    = 19;
  localparam int unsigned SHIFT_100   = 23;
  localparam int unsigned SHIFT_1000  = 26;
  localparam int unsigned SHIFT_10000 = 30;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [12:0]        q1;   // value / 10
    logic [9:0]         q2;   // value / 100
    logic [6:0]         q3;   // value / 1000
    logic [2:0]         q4;   // value / 10000
  } quot_t;

  typedef struct packed {
    logic [SEL_W-1:0] sel;
    logic [SEG_W-1:0] seg;
  } res_t;

  // x * 10 as shift and add
  function automatic logic [VALUE_W-1:0] times10(input logic [VALUE_W-1:0] x);
    times10 = (x << 3) + (x << 1);
  endfunction

  // Active-low segment pattern, bit 7 is the decimal point (off)
  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h98;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/bin7seg_div.sv
`timescale 1ns / 1ps

// Input register, then four constant-reciprocal multiplies into a quotient register.
module bin7seg_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bin7seg_pkg::VALUE_W-1:0]     value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bin7seg_pkg::quot_t                  quot
);

  logic                              a_valid;
  logic [bin7seg_pkg::VALUE_W-1:0]   a_value;
  logic                              b_valid;
  bin7seg_pkg::quot_t                b_quot;
  bin7seg_pkg::quot_t                quot_next;
  logic [bin7seg_pkg::PROD_W-1:0]    p1, p2, p3, p4, a_ext;
  logic                              a_free, b_free;

  assign b_free   = !b_valid || out_ready;
  assign a_free   = !a_valid || b_free;
  assign in_ready = a_free;

  assign a_ext = {{bin7seg_pkg::RECIP_W{1'b0}}, a_value};
  assign p1 = a_ext * bin7seg_pkg::PROD_W'(bin7seg_pkg::RECIP_10);
  assign p2 = a_ext * bin7seg_pkg::PROD_W'(bin7seg_pkg::RECIP_100);
  assign p3 = a_ext * bin7seg_pkg::PROD_W'(bin7seg_pkg::RECIP_1000);
  assign p4 = a_ext * bin7seg_pkg::PROD_W'(bin7seg_pkg::RECIP_10000);

  always_comb begin
    quot_next.value = a_value;
    quot_next.q1    = 13'(p1 >> bin7seg_pkg::SHIFT_10);
    quot_next.q2    = 10'(p2 >> bin7seg_pkg::SHIFT_100);
    quot_next.q3    = 7'(p3 >> bin7seg_pkg::SHIFT_1000);
    quot_next.q4    = 3'(p4 >> bin7seg_pkg::SHIFT_10000);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_free) a_valid <= in_valid;
      if (b_free) b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_free) a_value <= value;
    if (a_valid && b_free)  b_quot  <= quot_next;
  end

  assign out_valid = b_valid;
  assign quot      = b_quot;

endmodule

### hw/rtl/bin7seg_fmt.sv
`timescale 1ns / 1ps

// Remainders, segment lookup and leading-zero suppression.
module bin7seg_fmt (
  input  bin7seg_pkg::quot_t  quot,
  output bin7seg_pkg::res_t   res [bin7seg_pkg::NUM_DIG],
  output logic [1:0]          last_idx
);

  logic [bin7seg_pkg::VALUE_W-1:0] r0, r1, r2, r3;

  // remainder of each quotient against ten times the next one
  assign r0 = quot.value - bin7seg_pkg::times10(16'(quot.q1));
  assign r1 = 16'(quot.q1) - bin7seg_pkg::times10(16'(quot.q2));
  assign r2 = 16'(quot.q2) - bin7seg_pkg::times10(16'(quot.q3));
  assign r3 = 16'(quot.q3) - bin7seg_pkg::times10(16'(quot.q4));

  always_comb begin
    res[0] = '{sel: bin7seg_pkg::SEL_ONES,      seg: bin7seg_pkg::seg_of(r0[3:0])};
    res[1] = '{sel: bin7seg_pkg::SEL_TENS,      seg: bin7seg_pkg::seg_of(r1[3:0])};
    res[2] = '{sel: bin7seg_pkg::SEL_HUNDREDS,  seg: bin7seg_pkg::seg_of(r2[3:0])};
    res[3] = '{sel: bin7seg_pkg::SEL_THOUSANDS, seg: bin7seg_pkg::seg_of(r3[3:0])};
    priority if (quot.q1 == '0) begin
      // single digit: blank the thousands position after it
      res[1]   = '{sel: bin7seg_pkg::SEL_THOUSANDS, seg: bin7seg_pkg::SEG_BLANK};
      last_idx = 2'd1;
    end else if (quot.q2 == '0) begin
      last_idx = 2'd1;
    end else if (quot.q3 == '0) begin
      last_idx = 2'd2;
    end else begin
      last_idx = 2'd3;
    end
  end

endmodule

### hw/rtl/bin7seg_ser.sv
`timescale 1ns / 1ps

// Holds one value's digit words and shifts them out, ones digit first.
module bin7seg_ser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bin7seg_pkg::res_t  res [bin7seg_pkg::NUM_DIG],
  input  logic [1:0]         last_idx,
  output logic               out_valid,
  input  logic               out_ready,
  output bin7seg_pkg::res_t  out_res,
  output logic               out_last
);

  logic               busy;
  logic [1:0]         remaining;
  bin7seg_pkg::res_t  words [bin7seg_pkg::NUM_DIG];
  logic               load_ok;

  assign load_ok  = !busy || (out_ready && remaining == 2'd0);
  assign in_ready = load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      remaining <= 2'd0;
    end else if (load_ok) begin
      busy      <= in_valid;
      remaining <= last_idx;
    end else if (out_ready) begin
      remaining <= remaining - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      words <= res;
    end else if (out_ready) begin
      for (int i = 0; i < bin7seg_pkg::NUM_DIG - 1; i++) begin
        words[i] <= words[i+1];
      end
    end
  end

  assign out_valid = busy;
  assign out_res   = words[0];
  assign out_last  = (remaining == 2'd0);

endmodule

### hw/rtl/binary_to_seven_segment_digits_top.sv
`timescale 1ns / 1ps

// Binary to seven-segment digit decoder. Each 16-bit input word is split into
// ones, tens, hundreds and thousands digits (thousands taken mod 10, so values
// above 9999 wrap in that digit) and each shown digit leaves as one output word
// carrying a position select (0 ones, 1 tens, 3 hundreds, 4 thousands) and an
// active-low segment pattern, ones digit first, tlast on the final word.
// Leading zeros are dropped; a one-digit value is followed by a blank pattern
// (0xFF) to position 4. An input word yields 2, 3 or 4 output words, one per
// cycle while m_tready is high; the serializer loads the next value as the last
// word of the previous one leaves. Input to first output word passes the input
// register, quotient register and serializer. Input is taken while earlier
// words are in flight or waiting at the output, as long as the input register
// is empty or can hand its word on to the quotient register.
module binary_to_seven_segment_digits_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] digit_select, [10:3] segments, [15:11] zero
  output logic        m_tlast
);

  bin7seg_pkg::quot_t  quot;
  logic                quot_valid;
  logic                quot_ready;
  bin7seg_pkg::res_t   res [bin7seg_pkg::NUM_DIG];
  logic [1:0]          last_idx;
  bin7seg_pkg::res_t   out_res;

  // Stage 1-2: input register and divide-by-constant products
  bin7seg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .value     (s_tdata),
    .out_valid (quot_valid),
    .out_ready (quot_ready),
    .quot      (quot)
  );

  // Digits and segment patterns straight into the serializer's load port
  bin7seg_fmt u_fmt (
    .quot     (quot),
    .res      (res),
    .last_idx (last_idx)
  );

  // Output register: one digit word per cycle while m_tready is high
  bin7seg_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (quot_valid),
    .in_ready  (quot_ready),
    .res       (res),
    .last_idx  (last_idx),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res),
    .out_last  (m_tlast)
  );

  assign m_tdata = {5'b0, out_res.seg, out_res.sel};

endmodule
